[rtl/asrdp_pkg.sv]
// shared types and constants for the ata status return descriptor parser
`default_nettype none
package asrdp_pkg;

	localparam int POS_W = 8;
	localparam int Q_DEPTH = 2;

	localparam logic [7:0] RESP_CODE_CUR = 8'h72;
	localparam logic [7:0] RESP_CODE_DEF = 8'h73;
	localparam logic [7:0] MIN_ADD_LEN = 8'd14;
	localparam logic [7:0] ATA_DESC_CODE = 8'h09;
	localparam logic [7:0] MIN_DESC_LEN = 8'h0C;
	localparam logic [7:0] FIRST_DESC = 8'd8;
	localparam logic [15:0] NO_PROGRESS = 16'hFFFF;

	localparam logic [7:0] OFF_ERROR = 8'd3;
	localparam logic [7:0] OFF_COUNT_HI = 8'd4;
	localparam logic [7:0] OFF_COUNT_LO = 8'd5;
	localparam logic [7:0] OFF_PROG_HI = 8'd8;
	localparam logic [7:0] OFF_PROG_LO = 8'd9;
	localparam logic [7:0] OFF_STATUS = 8'd13;

	typedef enum logic [2:0] {
		RSN_OK        = 3'd0,
		RSN_BAD_RESP  = 3'd1,
		RSN_SHORT_ADD = 3'd2,
		RSN_ZERO_LEN  = 3'd3,
		RSN_OVERRUN   = 3'd4,
		RSN_SHORT_DSC = 3'd5,
		RSN_NOT_FOUND = 3'd6
	} reason_t;

	typedef struct packed {
		logic        taken;
		reason_t     code;
		logic [7:0]  error;
		logic [7:0]  status;
		logic [15:0] count;
		logic [15:0] progress;
	} verdict_t;

endpackage
`default_nettype wire

[rtl/asrdp_front.sv]
// front end: walks the sense buffer byte by byte and builds the verdict record
`default_nettype none
module asrdp_front #(
	parameter int SENSE_BYTES = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sense_valid,
	output logic                     sense_stall,
	input  wire logic [7:0]          sense_byte,
	input  wire logic                q_full,
	output logic                     q_push,
	output asrdp_pkg::verdict_t      q_wdata
);
	import asrdp_pkg::*;

	localparam logic [POS_W-1:0] LAST = POS_W'(SENSE_BYTES - 1);
	localparam logic [9:0] BUF_LEN = 10'(SENSE_BYTES);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] start_q, start_d;
	logic [7:0]       dcode_q, dcode_d;
	logic             taken_q, taken_d;
	reason_t          code_q, code_d;
	logic [7:0]       error_q, error_d;
	logic [7:0]       status_q, status_d;
	logic [15:0]      count_q, count_d;
	logic [15:0]      prog_q, prog_d;

	logic             last;
	logic             accept;
	logic [8:0]       start_p1;
	logic [9:0]       desc_end;
	logic [POS_W-1:0] off;

	assign last = (pos_q == LAST);
	assign sense_stall = last && q_full;
	assign accept = sense_valid && !sense_stall;
	assign start_p1 = {1'b0, start_q} + 9'd1;
	assign desc_end = {2'b00, start_q} + 10'd2 + {2'b00, sense_byte};
	assign off = pos_q - start_q;

	always_comb begin
		start_d = start_q;
		dcode_d = dcode_q;
		taken_d = taken_q;
		code_d = code_q;
		error_d = error_q;
		status_d = status_q;
		count_d = count_q;
		prog_d = prog_q;
		if (!taken_q) begin
			if (pos_q == '0) begin
				if (sense_byte != RESP_CODE_CUR && sense_byte != RESP_CODE_DEF) begin
					taken_d = 1'b1;
					code_d = RSN_BAD_RESP;
				end
			end else if (pos_q == POS_W'(7)) begin
				if (sense_byte < MIN_ADD_LEN) begin
					taken_d = 1'b1;
					code_d = RSN_SHORT_ADD;
				end
			end else if (pos_q >= FIRST_DESC && pos_q == start_q
					&& start_p1 < BUF_LEN[8:0]) begin
				dcode_d = sense_byte;
			end else if (pos_q >= POS_W'(9) && {1'b0, pos_q} == start_p1) begin
				if (sense_byte == 8'd0) begin
					taken_d = 1'b1;
					code_d = RSN_ZERO_LEN;
				end else if (desc_end > BUF_LEN) begin
					taken_d = 1'b1;
					code_d = RSN_OVERRUN;
				end else if (dcode_q == ATA_DESC_CODE) begin
					taken_d = 1'b1;
					code_d = (sense_byte < MIN_DESC_LEN) ? RSN_SHORT_DSC : RSN_OK;
				end else begin
					start_d = desc_end[POS_W-1:0];
				end
			end
		end else if (code_q == RSN_OK && pos_q > start_q) begin
			case (off)
				OFF_ERROR:    error_d = sense_byte;
				OFF_COUNT_HI: count_d = {sense_byte, count_q[7:0]};
				OFF_COUNT_LO: count_d = {count_q[15:8], sense_byte};
				OFF_PROG_HI:  prog_d = {sense_byte, prog_q[7:0]};
				OFF_PROG_LO:  prog_d = {prog_q[15:8], sense_byte};
				OFF_STATUS:   status_d = sense_byte;
				default: ;
			endcase
		end
	end

	assign q_push = accept && last;
	assign q_wdata = '{taken: taken_d, code: code_d, error: error_d, status: status_d,
		count: count_d, progress: prog_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			start_q <= FIRST_DESC;
			dcode_q <= '0;
			taken_q <= 1'b0;
			code_q <= RSN_OK;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				start_q <= FIRST_DESC;
				dcode_q <= '0;
				taken_q <= 1'b0;
				code_q <= RSN_OK;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				start_q <= start_d;
				dcode_q <= dcode_d;
				taken_q <= taken_d;
				code_q <= code_d;
			end
		end
	end

	// captured fields are only shown after a clean verdict, which rewrites them all
	always_ff @(posedge clk) begin
		if (accept) begin
			error_q <= error_d;
			status_q <= status_d;
			count_q <= count_d;
			prog_q <= prog_d;
		end
	end

endmodule
`default_nettype wire

[rtl/asrdp_queue.sv]
// short queue of verdict records between front and back
`default_nettype none
module asrdp_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire asrdp_pkg::verdict_t wdata,
	output logic                     full,
	input  wire logic                pop,
	output logic                     rvalid,
	output asrdp_pkg::verdict_t      rdata
);
	import asrdp_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	verdict_t         mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full = (cnt_q == CNT_W'(Q_DEPTH));
	assign rvalid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && rvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

[rtl/asrdp_back.sv]
// back end: turns a verdict record into the result item and holds it for the sink
`default_nettype none
module asrdp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire asrdp_pkg::verdict_t q_rdata,
	output logic                     q_pop,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic                     found,
	output logic [2:0]               fail_reason,
	output logic [7:0]               ata_error,
	output logic [7:0]               ata_status,
	output logic                     completed_ok,
	output logic                     in_progress,
	output logic                     sanitize_frozen,
	output logic [15:0]              progress
);
	import asrdp_pkg::*;

	logic        valid_q;
	logic        ok;
	logic [15:0] cnt;

	assign q_pop = q_valid && (!valid_q || !result_stall);
	assign ok = q_rdata.taken && (q_rdata.code == RSN_OK);
	assign cnt = ok ? q_rdata.count : 16'd0;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			found <= ok;
			fail_reason <= q_rdata.taken ? q_rdata.code : RSN_NOT_FOUND;
			ata_error <= ok ? q_rdata.error : 8'd0;
			ata_status <= ok ? q_rdata.status : 8'd0;
			completed_ok <= cnt[15];
			in_progress <= cnt[14];
			sanitize_frozen <= cnt[13];
			progress <= cnt[14] ? q_rdata.progress : NO_PROGRESS;
		end
	end

endmodule
`default_nettype wire

[rtl/ata_status_return_descriptor_parser.sv]
// top level of the ata status return descriptor parser
// takes one sense byte per cycle while not stalled, no gaps needed between buffers
// a buffer's verdict passes through the queue, then the output register, to the result
// a two-entry verdict queue lets the front keep taking bytes while results wait
// reset clears the byte position, descriptor walk and verdict, queue and output valid
`default_nettype none
module ata_status_return_descriptor_parser #(
	parameter int SENSE_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sense_valid,
	output logic             sense_stall,
	input  wire logic [7:0]  sense_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             found,
	output logic [2:0]       fail_reason,
	output logic [7:0]       ata_error,
	output logic [7:0]       ata_status,
	output logic             completed_ok,
	output logic             in_progress,
	output logic             sanitize_frozen,
	output logic [15:0]      progress
);
	import asrdp_pkg::*;

	verdict_t push_data, pop_data;
	logic     push, q_full, pop, q_valid;

	asrdp_front #(
		.SENSE_BYTES(SENSE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sense_valid(sense_valid),
		.sense_stall(sense_stall),
		.sense_byte (sense_byte),
		.q_full     (q_full),
		.q_push     (push),
		.q_wdata    (push_data)
	);

	asrdp_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_data),
		.full  (q_full),
		.pop   (pop),
		.rvalid(q_valid),
		.rdata (pop_data)
	);

	asrdp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_rdata        (pop_data),
		.q_pop          (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.found          (found),
		.fail_reason    (fail_reason),
		.ata_error      (ata_error),
		.ata_status     (ata_status),
		.completed_ok   (completed_ok),
		.in_progress    (in_progress),
		.sanitize_frozen(sanitize_frozen),
		.progress       (progress)
	);

endmodule
`default_nettype wire
